[design/u16u8_pkg.sv]
`timescale 1ns / 1ps

package u16u8_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_LONE_LOW    = 2'd1,
        ST_HIGH_NO_LOW = 2'd2,
        ST_HIGH_AT_END = 2'd3
    } t_status;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // One queued command: the bytes of one run, already encoded
    typedef struct packed {
        logic [3:0][7:0] bytes;     // byte 0 goes out first
        logic [1:0]      last_idx;  // index of the final byte (run length - 1)
        t_status         status;
        logic            eos;
    } t_cmd;

    // Queue state seen by the back end
    typedef struct packed {
        logic not_empty;
        t_cmd head;
    } t_q_rd;

endpackage

[design/u16u8_front.sv]
`timescale 1ns / 1ps

module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_code_unit,
    input  logic              i_eos,
    output logic              o_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output u16u8_pkg::t_cmd   o_cmd
);

    logic        r_pending;
    logic [9:0]  r_held;
    logic        n_pending;
    logic [9:0]  n_held;
    logic        w_accept;
    logic        w_is_high;
    logic        w_is_low;
    logic [20:0] w_cp;
    logic        w_emit;

    assign o_ready   = !i_q_full;
    assign w_accept  = i_valid && o_ready;
    assign w_is_high = (i_code_unit[15:10] == 6'b110110);
    assign w_is_low  = (i_code_unit[15:10] == 6'b110111);

    always_comb begin
        n_pending = r_pending;
        n_held    = r_held;
        w_emit    = 1'b1;
        w_cp      = {5'd0, i_code_unit};
        o_cmd     = '0;
        o_cmd.eos = i_eos;
        o_cmd.status = u16u8_pkg::ST_OK;

        if (r_pending) begin
            n_pending = 1'b0;
            n_held    = '0;
            if (w_is_low) begin
                w_cp = 21'h10000 + {1'b0, r_held, i_code_unit[9:0]};
            end else begin
                o_cmd.status = u16u8_pkg::ST_HIGH_NO_LOW;
            end
        end else if (w_is_high) begin
            if (i_eos) begin
                o_cmd.status = u16u8_pkg::ST_HIGH_AT_END;
            end else begin
                n_pending = 1'b1;
                n_held    = i_code_unit[9:0];
                w_emit    = 1'b0;
            end
        end else if (w_is_low) begin
            o_cmd.status = u16u8_pkg::ST_LONE_LOW;
        end

        // Encode; an error run is a single zero byte
        if (o_cmd.status == u16u8_pkg::ST_OK) begin
            if (w_cp[20:16] != '0) begin
                o_cmd.bytes[0] = 8'hF0 | {5'd0, w_cp[20:18]};
                o_cmd.bytes[1] = 8'h80 | {2'd0, w_cp[17:12]};
                o_cmd.bytes[2] = 8'h80 | {2'd0, w_cp[11:6]};
                o_cmd.bytes[3] = 8'h80 | {2'd0, w_cp[5:0]};
                o_cmd.last_idx = 2'd3;
            end else if (w_cp[15:11] != '0) begin
                o_cmd.bytes[0] = 8'hE0 | {4'd0, w_cp[15:12]};
                o_cmd.bytes[1] = 8'h80 | {2'd0, w_cp[11:6]};
                o_cmd.bytes[2] = 8'h80 | {2'd0, w_cp[5:0]};
                o_cmd.last_idx = 2'd2;
            end else if (w_cp[10:7] != '0) begin
                o_cmd.bytes[0] = 8'hC0 | {3'd0, w_cp[10:6]};
                o_cmd.bytes[1] = 8'h80 | {2'd0, w_cp[5:0]};
                o_cmd.last_idx = 2'd1;
            end else begin
                o_cmd.bytes[0] = {1'b0, w_cp[6:0]};
                o_cmd.last_idx = 2'd0;
            end
        end
    end

    assign o_push = w_accept && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= '0;
        end else if (w_accept) begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule

[design/u16u8_queue.sv]
`timescale 1ns / 1ps

module u16u8_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u16u8_pkg::t_cmd   i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output u16u8_pkg::t_q_rd  o_rd
);

    u16u8_pkg::t_cmd              r_mem [u16u8_pkg::QDepth];
    logic [u16u8_pkg::QAw-1:0]    r_wptr;
    logic [u16u8_pkg::QAw-1:0]    r_rptr;
    logic [u16u8_pkg::QAw:0]      r_count;

    assign o_full       = (r_count == (u16u8_pkg::QAw+1)'(u16u8_pkg::QDepth));
    assign o_rd.not_empty = (r_count != '0);
    assign o_rd.head    = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/u16u8_back.sv]
`timescale 1ns / 1ps

module u16u8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  u16u8_pkg::t_q_rd  i_rd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_last,
    output logic [1:0]        o_status,
    output logic              o_done
);

    logic            r_busy;
    u16u8_pkg::t_cmd r_cmd;
    logic [1:0]      r_idx;
    logic            w_final;

    assign w_final  = (r_idx == r_cmd.last_idx);
    assign o_pop    = i_rd.not_empty && (!r_busy || (i_ready && w_final));

    assign o_valid  = r_busy;
    assign o_byte   = r_cmd.bytes[r_idx];
    assign o_last   = w_final;
    assign o_status = r_cmd.status;
    assign o_done   = w_final && r_cmd.eos;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_rd.head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

[design/utf16_to_utf8_transcoder_top.sv]
`timescale 1ns / 1ps

// UTF-16 to UTF-8 transcoder. One UTF-16 code unit per slave transaction
// (tdata = code unit, tlast = end of string); one UTF-8 byte per master
// transaction, tlast on the final byte of each run, tuser carrying the
// status and an end-of-string flag. A high surrogate is held and gives no
// output until the next unit; a following low surrogate yields a 4-byte
// code point. A lone low surrogate, a high surrogate followed by anything
// but a low one, or a high surrogate at end of string each yield a single
// zero byte with a non-zero status; the held unit and the next are dropped.
// Throughput: the front end takes one unit per cycle while the 4-entry
// command queue has room; the byte serialiser emits one byte per cycle
// while the sink is ready, a unit yielding 1 to 3 bytes (4 bytes per
// surrogate pair, 1 per error), so the byte count sets the sustained rate.
module utf16_to_utf8_transcoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // end_of_string
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_last
    output logic [2:0]  m_axis_tuser    // [1:0] status, [2] string_done
);

    logic              w_full;
    logic              w_push;
    logic              w_pop;
    u16u8_pkg::t_cmd   w_cmd;
    u16u8_pkg::t_q_rd  w_rd;
    logic [1:0]        w_status;
    logic              w_done;

    // Front end: surrogate tracking, classification and encoding
    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_code_unit (s_axis_tdata),
        .i_eos       (s_axis_tlast),
        .o_ready     (s_axis_tready),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    // Command queue decoupling the two sides
    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rd    (w_rd)
    );

    // Back end: byte serialiser with registered run
    u16u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (w_rd),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_status (w_status),
        .o_done   (w_done)
    );

    assign m_axis_tuser = {w_done, w_status};

endmodule
